FILE: sv/sidt_pkg.sv
package sidt_pkg;

  // ASCII codes, cut to the 6-bit character field
  localparam logic [5:0] CharZero  = 6'd48;
  localparam logic [5:0] CharMinus = 6'd45;

  // Sequencer commands to the divide-by-ten unit
  typedef struct packed {
    logic load;   // take a new magnitude
    logic mul;    // form the first reciprocal product
    logic step;   // retire one digit, advance to the quotient
  } sidt_ctl_t;

endpackage

FILE: sv/sidt_div10.sv
module sidt_div10 #(
  parameter int VALUE_BITS = 16
) (
  input  logic                    clk,
  input  sidt_pkg::sidt_ctl_t     ctl,
  input  logic [VALUE_BITS-1:0]   load_mag,
  output logic [3:0]              digit,
  output logic                    quot_zero
);

  localparam int ProdW = 2 * VALUE_BITS;
  localparam int Shift = VALUE_BITS + 3;
  localparam logic [63:0] RecipFull = ((64'd1 << Shift) / 64'd10) + 64'd1;
  localparam logic [VALUE_BITS-1:0] Recip = RecipFull[VALUE_BITS-1:0];

  logic [VALUE_BITS-1:0] div_r;
  logic [ProdW-1:0]      prod_r;
  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] mul_a;
  logic [ProdW-1:0]      prod_nxt;
  logic [3:0]            quot_x10;

  // q = floor(x / 10) = (x * Recip) >> Shift, exact for any x below 2^VALUE_BITS
  assign quot = VALUE_BITS'(prod_r[ProdW-1:Shift]);

  // only the low nibble of 10*q matters, the remainder is below ten
  assign quot_x10  = {quot[0], 3'b000} + {quot[2:0], 1'b0};
  assign digit     = div_r[3:0] - quot_x10;
  assign quot_zero = (quot == '0);

  assign mul_a    = ctl.step ? quot : div_r;
  assign prod_nxt = ProdW'(mul_a) * ProdW'(Recip);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      div_r <= load_mag;
    end else if (ctl.step) begin
      div_r <= quot;
    end
    if (ctl.mul || ctl.step) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

FILE: sv/signed_int_to_decimal_text_core.sv
// Renders one signed integer per item as decimal ASCII, sign first, MS digit first.
// Per item with D digits (D = 1..5 at 16 bits): a reciprocal multiply, then
// one divide-by-ten step per digit through the shared reciprocal multiplier,
// then a minus sign for a negative value and the D digit characters, which
// wait while out_stall holds them. No new item is taken until idle again.
// rst_n (synchronous) returns the sequencer to idle and drops the output valid.
module signed_int_to_decimal_text_core #(
  parameter int VALUE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [5:0]            out_character,
  output logic                  out_last
);

  localparam int MaxDigits = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int CntW      = $clog2(MaxDigits + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_DIG  = 5'b00100,
    ST_SIGN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t              state_r, state_nxt;
  logic                neg_r;
  logic [CntW-1:0]     cnt_r;
  logic [3:0]          stk_r [MaxDigits];
  logic                out_valid_r;
  logic [5:0]          out_character_r;
  logic                out_last_r;

  sidt_pkg::sidt_ctl_t ctl;
  logic                accept;
  logic                out_free;
  logic                in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [3:0]          digit;
  logic                quot_zero;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // magnitude taken as unsigned so the most negative value survives
  assign in_neg = in_value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_value + VALUE_BITS'(1)) : in_value;

  assign ctl.load = accept;
  assign ctl.mul  = (state_r == ST_MUL);
  assign ctl.step = (state_r == ST_DIG);

  sidt_div10 #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div10 (
    .clk      (clk),
    .ctl      (ctl),
    .load_mag (in_mag),
    .digit    (digit),
    .quot_zero(quot_zero)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_DIG;
      end
      ST_DIG: begin
        if (quot_zero) state_nxt = neg_r ? ST_SIGN : ST_EMIT;
      end
      ST_SIGN: begin
        if (out_free) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (cnt_r == CntW'(1))) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == ST_DIG) begin
        cnt_r <= cnt_r + CntW'(1);
      end else if ((state_r == ST_EMIT) && out_free) begin
        cnt_r <= cnt_r - CntW'(1);
      end
      if (((state_r == ST_SIGN) || (state_r == ST_EMIT)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // digits arrive least significant first: push on a stack, pop to emit
  always_ff @(posedge clk) begin
    if (accept) begin
      neg_r <= in_neg;
    end
    if (state_r == ST_DIG) begin
      stk_r[0] <= digit;
      for (int i = 1; i < MaxDigits; i++) begin
        stk_r[i] <= stk_r[i-1];
      end
    end else if ((state_r == ST_EMIT) && out_free) begin
      for (int i = 0; i < MaxDigits - 1; i++) begin
        stk_r[i] <= stk_r[i+1];
      end
      stk_r[MaxDigits-1] <= 4'd0;
    end
    if ((state_r == ST_SIGN) && out_free) begin
      out_character_r <= sidt_pkg::CharMinus;
      out_last_r      <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_character_r <= sidt_pkg::CharZero + {2'b00, stk_r[0]};
      out_last_r      <= (cnt_r == CntW'(1));
    end
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int ValueBits   = 16;
  localparam int NumRows     = 21;
  localparam int NumRandom   = 480;
  localparam int LongHold    = 400;
  localparam int TailCycles  = 40;
  localparam int CycleLimit  = 200000;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
  } text_char_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ValueBits-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [5:0]           out_character;
  logic                 out_last;

  text_char_t char_queue [$];
  int         fail_count = 0;
  int         cycle_count = 0;
  logic       hold_req = 1'b0;

  // Directed table: typed text where it is obvious, empty text means predicted
  logic [ValueBits-1:0] row_value [NumRows] = '{
    16'h0000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8001,
    16'h0009, 16'h000A, 16'h0063, 16'h0064, 16'h03E7, 16'h03E8,
    16'h270F, 16'h2710, 16'hFFF7, 16'hFFF6, 16'hD8F0, 16'h3039,
    16'hCFC7, 16'h5555, 16'hAAAA
  };
  string row_text [NumRows] = '{
    "0", "1", "-1", "32767", "-32768", "-32767",
    "", "", "", "", "", "",
    "", "", "", "", "", "",
    "", "", ""
  };

  signed_int_to_decimal_text_core #(
    .VALUE_BITS(ValueBits)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_character(out_character),
    .out_last     (out_last)
  );

  always #5 clk = ~clk;

  // Expected characters of one value: sign, then digits MS first
  function automatic void queue_decimal_text(input logic [ValueBits-1:0] value);
    logic [ValueBits-1:0] mag;
    int unsigned          rest;
    logic [3:0]           digit_q [$];
    text_char_t           ch;
    mag = value[ValueBits-1] ? (~value + 1'b1) : value;
    rest = mag;
    if (rest == 0) begin
      ch.code = sidt_pkg::CharZero;
      ch.last = 1'b1;
      char_queue.push_back(ch);
    end else begin
      while (rest != 0) begin
        digit_q.push_front(4'(rest % 10));
        rest = rest / 10;
      end
      if (value[ValueBits-1]) begin
        ch.code = sidt_pkg::CharMinus;
        ch.last = 1'b0;
        char_queue.push_back(ch);
      end
      foreach (digit_q[i]) begin
        ch.code = sidt_pkg::CharZero + 6'(digit_q[i]);
        ch.last = (i == digit_q.size() - 1);
        char_queue.push_back(ch);
      end
    end
  endfunction

  function automatic void queue_typed_text(input string text);
    byte        b;
    text_char_t ch;
    for (int i = 0; i < text.len(); i++) begin
      b = text[i];
      ch.code = b[5:0];
      ch.last = (i == text.len() - 1);
      char_queue.push_back(ch);
    end
  endfunction

  function automatic logic [ValueBits-1:0] random_value();
    int unsigned          pick;
    int unsigned          digits;
    int unsigned          lo;
    int unsigned          hi;
    int unsigned          mag;
    logic [ValueBits-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      v = ValueBits'($urandom);
    end else begin
      if (pick < 70) begin
        // pick a digit count first so short numbers are common
        digits = $urandom_range(1, 5);
        lo = (digits == 1) ? 0 : 10 ** (digits - 1);
        hi = (digits == 5) ? 32767 : 10 ** digits - 1;
        mag = $urandom_range(hi, lo);
      end else if (pick < 85) begin
        mag = 10 ** $urandom_range(1, 4) + $urandom_range(0, 2) - 1;
      end else begin
        case ($urandom_range(0, 3))
          0:       mag = 0;
          1:       mag = 1;
          2:       mag = 32767;
          default: mag = 32768;
        endcase
      end
      v = mag[ValueBits-1:0];
      if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
    end
    return v;
  endfunction

  task automatic offer_item(input logic [ValueBits-1:0] value, input string text);
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (text.len() == 0) queue_decimal_text(value);
    else queue_typed_text(text);
  endtask

  task automatic drain_chars();
    while (char_queue.size() != 0) @(posedge clk);
  endtask

  initial begin : drive_items
    int n;
    int burst_left;
    int gap;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (n = 0; n < NumRows; n++) offer_item(row_value[n], row_text[n]);
    in_valid <= 1'b0;
    drain_chars();

    burst_left = 0;
    for (n = 0; n < NumRandom; n++) begin
      if (n == 200) begin
        // long receiver hold while items keep coming: fill the block
        hold_req = 1'b1;
        burst_left = 80;
      end else if (n == 360) begin
        in_valid <= 1'b0;
        drain_chars();
        burst_left = $urandom_range(1, 30);
      end else if (burst_left <= 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      offer_item(random_value(), "");
      burst_left--;
    end

    in_valid <= 1'b0;
    drain_chars();
    repeat (TailCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : drive_stall
    stall_mode_t mode;
    int          left;
    int          held;
    mode = STALL_NONE;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        for (held = 0; held < LongHold; held++) @(posedge clk);
      end else begin
        if (left <= 0) begin
          mode = stall_mode_t'($urandom_range(0, 3));
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
          default:     out_stall <= left[0];
        endcase
      end
    end
  end

  task automatic note_mismatch(input string what, input int want, input int got);
    fail_count++;
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
  endtask

  always @(posedge clk) begin : check_chars
    text_char_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (char_queue.size() == 0) begin
        note_mismatch("unexpected item, character", -1, out_character);
      end else begin
        want = char_queue.pop_front();
        if (out_character !== want.code) note_mismatch("character", want.code, out_character);
        if (out_last !== want.last) note_mismatch("last", want.last, out_last);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d characters outstanding", $time, char_queue.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
